[src/sst_pkg.sv]
// sst_pkg: request/result payload types, controller command and status types,
// and the fixed codes (modes, status, register indexes, result and write kinds) of the switch table.
// No dependencies.
package sst_pkg;

    // Mode codes of a request
    localparam logic [2:0] MODE_FIND   = 3'd0;
    localparam logic [2:0] MODE_SCAN   = 3'd1;
    localparam logic [2:0] MODE_READ   = 3'd2;
    localparam logic [2:0] MODE_TOGGLE = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_LEVEL     = 3'd1;
    localparam logic [2:0] ST_COORD     = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_BAD_CODE  = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] REG_CUR_LEVEL  = 2'd0;
    localparam logic [1:0] REG_MAP_WIDTH  = 2'd1;
    localparam logic [1:0] REG_MAP_HEIGHT = 2'd2;

    // Result kinds selected by the controller
    localparam logic [2:0] RK_ERR    = 3'd0;
    localparam logic [2:0] RK_HIT    = 3'd1;
    localparam logic [2:0] RK_INSERT = 3'd2;
    localparam logic [2:0] RK_MISS   = 3'd3;
    localparam logic [2:0] RK_ACCESS = 3'd4;

    // Table write kinds
    localparam logic [1:0] WR_NONE   = 2'd0;
    localparam logic [1:0] WR_SWEEP  = 2'd1;
    localparam logic [1:0] WR_INSERT = 2'd2;
    localparam logic [1:0] WR_TOGGLE = 2'd3;

    localparam logic [7:0] EMPTY_STATE = 8'hFF;
    localparam logic [8:0] CODE_ALL    = 9'h1FF;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] level_sel;
        logic [7:0] x_coord;
        logic [7:0] y_coord;
        logic       on_value;
        logic [8:0] code_in;
    } req_t;

    typedef struct packed {
        logic [8:0] code_out;
        logic       found;
        logic [7:0] state_out;
        logic [2:0] status;
    } res_t;

    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] state;
    } entry_t;

    typedef struct packed {
        logic       load;
        logic       slot_inc;
        logic       rd_code;
        logic       sweep_inc;
        logic [1:0] wr_kind;
        logic       res_load;
        logic [2:0] res_kind;
        logic [2:0] res_status;
    } cmd_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       lvl_bad;
        logic       coord_bad;
        logic       code_bad;
        logic       hit;
        logic       empty;
        logic       slot_last;
        logic       sweep_last;
    } stat_t;

endpackage

[src/segmented_switch_table.sv]
// segmented_switch_table: top level of the per-level switch target table.
// Joins sst_ctrl and sst_dpath; types and codes come from sst_pkg.
//
//   channel   handshake            payload
//   request   start / busy         request (sst_pkg::req_t)
//   result    done, 1-cycle strobe result  (sst_pkg::res_t)
//   config    cfg_we               cfg_idx, cfg_wdata
//
// Find-or-insert and scan walk the slots of the level in order, 1 to
// SLOTS_PER_LEVEL of them: the single table read port walks one slot per
// cycle. Read and toggle access the coded entry directly; clear sweeps the
// whole table, and the error cases finish after decode. After reset busy stays
// high for a clearing pass over all LEVEL_COUNT*SLOTS_PER_LEVEL entries.
// done pulses for one cycle; start is taken in that same cycle.
module segmented_switch_table
#(
    parameter int SLOTS_PER_LEVEL = 32,
    parameter int SLOT_BITS       = 5,
    parameter int LEVEL_COUNT     = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  sst_pkg::req_t request,
    output logic          done,
    output sst_pkg::res_t result,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_idx,
    input  logic [8:0]    cfg_wdata
);

    sst_pkg::cmd_t  cmd;
    sst_pkg::stat_t stat;

    sst_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .stat  (stat),
        .cmd   (cmd)
    );

    sst_dpath
    #(
        .SLOTS_PER_LEVEL (SLOTS_PER_LEVEL),
        .SLOT_BITS       (SLOT_BITS),
        .LEVEL_COUNT     (LEVEL_COUNT)
    )
    u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .request   (request),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result)
    );

endmodule

[src/sst_ctrl.sv]
// sst_ctrl: sequencing state machine of the switch table.
// Drives sst_pkg::cmd_t to the datapath and reads back sst_pkg::stat_t.
// Depends on sst_pkg.
module sst_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output logic          done,
    input  sst_pkg::stat_t stat,
    output sst_pkg::cmd_t  cmd
);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_WALK   = 3'd3;
    localparam logic [2:0] S_ACCESS = 3'd4;
    localparam logic [2:0] S_CLEAR  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = !(state_reg == S_IDLE || state_reg == S_DONE);
    assign done = (state_reg == S_DONE);

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.wr_kind    = sst_pkg::WR_NONE;
        cmd.res_kind   = sst_pkg::RK_ERR;
        cmd.res_status = sst_pkg::ST_OK;

        case (state_reg)
            S_INIT:
            begin
                cmd.wr_kind   = sst_pkg::WR_SWEEP;
                cmd.sweep_inc = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE, S_DONE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_DECODE:
            begin
                // issue the read of slot 0, or of the coded entry
                cmd.slot_inc = 1'b1;
                cmd.rd_code  = (stat.mode == sst_pkg::MODE_READ) ||
                               (stat.mode == sst_pkg::MODE_TOGGLE);
                case (stat.mode)
                    sst_pkg::MODE_FIND:
                    begin
                        if (stat.lvl_bad)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = sst_pkg::ST_LEVEL;
                            state_next     = S_DONE;
                        end
                        else if (stat.coord_bad)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = sst_pkg::ST_COORD;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            state_next = S_WALK;
                        end
                    end
                    sst_pkg::MODE_SCAN:
                    begin
                        if (stat.lvl_bad)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = sst_pkg::ST_LEVEL;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            state_next = S_WALK;
                        end
                    end
                    sst_pkg::MODE_READ, sst_pkg::MODE_TOGGLE:
                    begin
                        if (stat.code_bad)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = sst_pkg::ST_BAD_CODE;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            state_next = S_ACCESS;
                        end
                    end
                    sst_pkg::MODE_CLEAR:
                    begin
                        state_next = S_CLEAR;
                    end
                    default:
                    begin
                        cmd.res_load = 1'b1;
                        state_next   = S_DONE;
                    end
                endcase
            end

            S_WALK:
            begin
                // evaluate the slot read last cycle, read the next one
                cmd.slot_inc = 1'b1;
                if (stat.hit)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = sst_pkg::RK_HIT;
                    state_next   = S_DONE;
                end
                else if (stat.mode == sst_pkg::MODE_FIND && stat.empty)
                begin
                    cmd.wr_kind  = sst_pkg::WR_INSERT;
                    cmd.res_load = 1'b1;
                    cmd.res_kind = sst_pkg::RK_INSERT;
                    state_next   = S_DONE;
                end
                else if (stat.slot_last)
                begin
                    cmd.res_load = 1'b1;
                    if (stat.mode == sst_pkg::MODE_FIND)
                    begin
                        cmd.res_status = sst_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.res_kind   = sst_pkg::RK_MISS;
                        cmd.res_status = sst_pkg::ST_NOT_FOUND;
                    end
                    state_next = S_DONE;
                end
            end

            S_ACCESS:
            begin
                if (stat.mode == sst_pkg::MODE_TOGGLE)
                begin
                    cmd.wr_kind = sst_pkg::WR_TOGGLE;
                end
                cmd.res_load = 1'b1;
                cmd.res_kind = sst_pkg::RK_ACCESS;
                state_next   = S_DONE;
            end

            S_CLEAR:
            begin
                cmd.wr_kind   = sst_pkg::WR_SWEEP;
                cmd.sweep_inc = 1'b1;
                if (stat.sweep_last)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_DONE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[src/sst_dpath.sv]
// sst_dpath: request and configuration registers, the slot table memory,
// slot and sweep counters, compare logic and the result register.
// Depends on sst_pkg; commanded by sst_ctrl.
module sst_dpath
#(
    parameter int SLOTS_PER_LEVEL = 32,
    parameter int SLOT_BITS       = 5,
    parameter int LEVEL_COUNT     = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_idx,
    input  logic [8:0]     cfg_wdata,
    input  sst_pkg::req_t  request,
    input  sst_pkg::cmd_t  cmd,
    output sst_pkg::stat_t stat,
    output sst_pkg::res_t  result
);

    localparam int DEPTH  = LEVEL_COUNT * SLOTS_PER_LEVEL;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SC_W   = $clog2(SLOTS_PER_LEVEL + 1);
    localparam logic [8:0] SLOT_MASK = 9'((1 << SLOT_BITS) - 1);

    // configuration
    logic [3:0] cur_level_reg;
    logic [8:0] map_w_reg;
    logic [8:0] map_h_reg;

    // latched request
    logic [2:0] mode_reg;
    logic [7:0] lvl_reg;
    logic [7:0] x_reg;
    logic [7:0] y_reg;
    logic       on_reg;
    logic [8:0] code_reg;

    logic [SC_W-1:0]   slot_reg;
    logic [ADDR_W-1:0] sweep_reg;
    sst_pkg::entry_t   rd_data_reg;
    sst_pkg::res_t     res_reg;
    sst_pkg::res_t     res_next;

    sst_pkg::entry_t mem [DEPTH];

    logic [7:0]        lvl_next;
    logic [8:0]        code_lvl;
    logic [8:0]        code_slot;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] code_pos;
    logic [SC_W-1:0]   rd_slot;
    logic [SC_W-1:0]   eval_slot;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    sst_pkg::entry_t   wr_data;
    logic              wr_en;
    logic [8:0]        pack_code;
    logic [7:0]        acc_state;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_level_reg <= 4'd0;
            map_w_reg     <= 9'd64;
            map_h_reg     <= 9'd64;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                sst_pkg::REG_CUR_LEVEL:  cur_level_reg <= cfg_wdata[3:0];
                sst_pkg::REG_MAP_WIDTH:  map_w_reg     <= cfg_wdata;
                sst_pkg::REG_MAP_HEIGHT: map_h_reg     <= cfg_wdata;
                default:                 cur_level_reg <= cur_level_reg;
            endcase
        end
    end

    // scan always uses the current level; find takes it on the 255 code
    always_comb
    begin
        if (request.mode == sst_pkg::MODE_SCAN || request.level_sel == 8'hFF)
        begin
            lvl_next = {4'd0, cur_level_reg};
        end
        else
        begin
            lvl_next = request.level_sel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= request.mode;
            lvl_reg  <= lvl_next;
            x_reg    <= request.x_coord;
            y_reg    <= request.y_coord;
            on_reg   <= request.on_value;
            code_reg <= request.code_in;
        end
        if (cmd.res_load)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= '0;
            sweep_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                slot_reg <= '0;
            end
            else if (cmd.slot_inc)
            begin
                slot_reg <= slot_reg + SC_W'(1);
            end
            if (cmd.sweep_inc)
            begin
                sweep_reg <= stat.sweep_last ? '0 : sweep_reg + ADDR_W'(1);
            end
        end
    end

    // address generation
    assign code_lvl  = code_reg >> SLOT_BITS;
    assign code_slot = code_reg & SLOT_MASK;
    assign base      = ADDR_W'(ADDR_W'(lvl_reg) * ADDR_W'(SLOTS_PER_LEVEL));
    assign code_pos  = ADDR_W'(ADDR_W'(code_lvl) * ADDR_W'(SLOTS_PER_LEVEL))
                       + ADDR_W'(code_slot);
    assign rd_slot   = (slot_reg == SC_W'(SLOTS_PER_LEVEL)) ? '0 : slot_reg;
    assign eval_slot = slot_reg - SC_W'(1);
    assign rd_addr   = cmd.rd_code ? code_pos : base + ADDR_W'(rd_slot);
    assign acc_state = rd_data_reg.state ^ {7'd0, (mode_reg == sst_pkg::MODE_TOGGLE)};

    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = sweep_reg;
        wr_data = '{x: 8'hFF, y: 8'hFF, state: sst_pkg::EMPTY_STATE};
        case (cmd.wr_kind)
            sst_pkg::WR_SWEEP:
            begin
                wr_addr = sweep_reg;
            end
            sst_pkg::WR_INSERT:
            begin
                wr_addr = base + ADDR_W'(eval_slot);
                wr_data = '{x: x_reg, y: y_reg, state: {7'd0, on_reg}};
            end
            sst_pkg::WR_TOGGLE:
            begin
                wr_addr = code_pos;
                wr_data = '{x: rd_data_reg.x, y: rd_data_reg.y, state: acc_state};
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // status back to the controller
    always_comb
    begin
        stat.mode       = mode_reg;
        stat.lvl_bad    = (lvl_reg >= 8'(LEVEL_COUNT));
        stat.coord_bad  = (x_reg == 8'd0) || ({1'b0, x_reg} + 9'd1 >= map_w_reg) ||
                          (y_reg == 8'd0) || ({1'b0, y_reg} + 9'd1 >= map_h_reg);
        stat.code_bad   = (code_lvl >= 9'(LEVEL_COUNT)) ||
                          (code_slot >= 9'(SLOTS_PER_LEVEL));
        stat.hit        = (rd_data_reg.x == x_reg) && (rd_data_reg.y == y_reg);
        stat.empty      = (rd_data_reg.state == sst_pkg::EMPTY_STATE);
        stat.slot_last  = (slot_reg == SC_W'(SLOTS_PER_LEVEL));
        stat.sweep_last = (sweep_reg == ADDR_W'(DEPTH - 1));
    end

    assign pack_code = 9'((16'(lvl_reg) << SLOT_BITS) | (16'(eval_slot) & 16'(SLOT_MASK)));

    always_comb
    begin
        res_next        = '0;
        res_next.status = cmd.res_status;
        case (cmd.res_kind)
            sst_pkg::RK_HIT:
            begin
                res_next.code_out  = pack_code;
                res_next.found     = 1'b1;
                res_next.state_out = rd_data_reg.state;
            end
            sst_pkg::RK_INSERT:
            begin
                res_next.code_out  = pack_code;
                res_next.found     = 1'b1;
                res_next.state_out = {7'd0, on_reg};
            end
            sst_pkg::RK_MISS:
            begin
                res_next.code_out = sst_pkg::CODE_ALL;
            end
            sst_pkg::RK_ACCESS:
            begin
                res_next.code_out  = code_reg;
                res_next.found     = 1'b1;
                res_next.state_out = acc_state;
            end
            default:
            begin
                res_next.code_out = 9'd0;
            end
        endcase
    end

    assign result = res_reg;

endmodule

[tb/sv/segmented_switch_table_tb.sv]
// segmented_switch_table_tb: self-checking bench for the per-level switch table.
// Drives requests through start/busy, checks each done strobe against a local
// table predictor. Depends on sst_pkg and segmented_switch_table.
module segmented_switch_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS     = 32;
    localparam int SLOT_W    = 5;
    localparam int LEVELS    = 16;
    localparam int STALL_MAX = 4000;

    localparam logic [1:0] REG_SPARE      = 2'd3;
    localparam logic [2:0] MODE_NOP_FIRST = 3'd5;
    localparam logic [2:0] MODE_NOP_LAST  = 3'd7;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    sst_pkg::req_t request = '0;
    logic          done;
    sst_pkg::res_t result;
    logic          cfg_we = 1'b0;
    logic [1:0]    cfg_idx = '0;
    logic [8:0]    cfg_wdata = '0;

    segmented_switch_table i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predicted copy of the table and its registers
    bit [7:0] tab_x [LEVELS*SLOTS];
    bit [7:0] tab_y [LEVELS*SLOTS];
    bit [7:0] tab_st [LEVELS*SLOTS];
    bit [3:0] cur_level = 4'd0;
    bit [8:0] map_w = 9'd64;
    bit [8:0] map_h = 9'd64;

    sst_pkg::req_t pending_reqs [$];
    sst_pkg::res_t expected_results [$];

    int  sender_idle_pct = 0;
    int  err_count = 0;
    int  reqs_taken = 0;
    int  results_checked = 0;
    int  issued = 0;
    int  stall_cycles = 0;
    int  status_count [8];
    bit  req_taken = 1'b0;
    bit  drain_hold = 1'b0;

    function automatic void wipe_table();
        for (int p = 0; p < LEVELS*SLOTS; p++)
        begin
            tab_x[p] = sst_pkg::EMPTY_STATE;
            tab_y[p] = sst_pkg::EMPTY_STATE;
            tab_st[p] = sst_pkg::EMPTY_STATE;
        end
    endfunction

    // Work out the result of one request and update the predicted table
    function automatic sst_pkg::res_t predict_switch(sst_pkg::req_t r);
        sst_pkg::res_t o;
        int   lvl;
        int   slot;
        int   p;
        bit   walk_done;
        bit   coord_bad;
        o = '0;
        walk_done = 1'b0;
        case (r.mode)
            sst_pkg::MODE_FIND, sst_pkg::MODE_SCAN:
            begin
                if (r.mode == sst_pkg::MODE_SCAN || r.level_sel == 8'hFF)
                    lvl = int'(cur_level);
                else
                    lvl = int'(r.level_sel);
                coord_bad = (r.x_coord == 0 || int'(r.x_coord) + 1 >= int'(map_w)
                             || r.y_coord == 0 || int'(r.y_coord) + 1 >= int'(map_h));
                if (lvl >= LEVELS)
                    o.status = sst_pkg::ST_LEVEL;
                else if (r.mode == sst_pkg::MODE_FIND && coord_bad)
                    o.status = sst_pkg::ST_COORD;
                else
                begin
                    for (int i = 0; i < SLOTS && !walk_done; i++)
                    begin
                        p = lvl * SLOTS + i;
                        if (tab_x[p] == r.x_coord && tab_y[p] == r.y_coord)
                        begin
                            o.state_out = tab_st[p];
                            walk_done = 1'b1;
                        end
                        else if (r.mode == sst_pkg::MODE_FIND
                                 && tab_st[p] == sst_pkg::EMPTY_STATE)
                        begin
                            // claim the first empty slot
                            tab_x[p] = r.x_coord;
                            tab_y[p] = r.y_coord;
                            tab_st[p] = {7'd0, r.on_value};
                            o.state_out = tab_st[p];
                            walk_done = 1'b1;
                        end
                        if (walk_done)
                        begin
                            o.code_out = 9'((lvl << SLOT_W) | i);
                            o.found = 1'b1;
                            o.status = sst_pkg::ST_OK;
                        end
                    end
                    if (!walk_done)
                    begin
                        if (r.mode == sst_pkg::MODE_FIND)
                            o.status = sst_pkg::ST_FULL;
                        else
                        begin
                            o.code_out = sst_pkg::CODE_ALL;
                            o.status = sst_pkg::ST_NOT_FOUND;
                        end
                    end
                end
            end
            sst_pkg::MODE_READ, sst_pkg::MODE_TOGGLE:
            begin
                lvl = int'(r.code_in >> SLOT_W);
                slot = int'(r.code_in[SLOT_W-1:0]);
                if (lvl >= LEVELS || slot >= SLOTS)
                    o.status = sst_pkg::ST_BAD_CODE;
                else
                begin
                    p = lvl * SLOTS + slot;
                    if (r.mode == sst_pkg::MODE_TOGGLE)
                        tab_st[p][0] = ~tab_st[p][0];
                    o.code_out = r.code_in;
                    o.found = 1'b1;
                    o.state_out = tab_st[p];
                    o.status = sst_pkg::ST_OK;
                end
            end
            sst_pkg::MODE_CLEAR: wipe_table();
            default: ;
        endcase
        return o;
    endfunction

    function automatic sst_pkg::req_t make_req(logic [2:0] m, logic [7:0] l, logic [7:0] x,
                                               logic [7:0] y, logic onv, logic [8:0] code);
        sst_pkg::req_t r;
        r.mode = m;
        r.level_sel = l;
        r.x_coord = x;
        r.y_coord = y;
        r.on_value = onv;
        r.code_in = code;
        return r;
    endfunction

    // Mostly well-formed traffic on a few levels and a small coordinate window
    function automatic sst_pkg::req_t random_request();
        sst_pkg::req_t r;
        bit [63:0]     raw;
        int            pick;
        int            lpick;
        raw = {$urandom, $urandom};
        r = raw[36:0];
        pick = $urandom_range(0, 199);
        if (pick < 120)
        begin
            r.mode = (pick < 90) ? sst_pkg::MODE_FIND : sst_pkg::MODE_SCAN;
            lpick = $urandom_range(0, 99);
            if (lpick < 60)
                r.level_sel = 8'($urandom_range(0, 3));
            else if (lpick < 80)
                r.level_sel = 8'hFF;
            if ($urandom_range(0, 99) < 85)
            begin
                r.x_coord = 8'($urandom_range(0, 12));
                r.y_coord = 8'($urandom_range(0, 12));
            end
            else if (r.mode == sst_pkg::MODE_SCAN)
            begin
                r.x_coord = sst_pkg::EMPTY_STATE;
                r.y_coord = sst_pkg::EMPTY_STATE;
            end
        end
        else if (pick < 175)
        begin
            r.mode = (pick < 150) ? sst_pkg::MODE_READ : sst_pkg::MODE_TOGGLE;
            if ($urandom_range(0, 99) < 60)
                r.code_in = {4'($urandom_range(0, 3)), 5'($urandom_range(0, 11))};
        end
        else if (pick < 177)
            r.mode = sst_pkg::MODE_CLEAR;
        else if (pick < 183)
            r.mode = 3'($urandom_range(MODE_NOP_FIRST, MODE_NOP_LAST));
        else
            r.mode = sst_pkg::MODE_FIND;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR @%0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        err_count++;
    endtask

    // Feed requests: hold start until taken, idle at random, drain now and then
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!(start && !req_taken))
        begin
            if (drain_hold && expected_results.size() == 0)
                drain_hold = 1'b0;
            if (pending_reqs.size() != 0 && !drain_hold
                && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                start <= 1'b1;
                request <= pending_reqs.pop_front();
                issued++;
                if (issued % 150 == 0)
                    drain_hold = 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // Check results, track register writes, predict accepted requests
    always @(posedge clk)
    begin
        sst_pkg::res_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with nothing pending", result, 0);
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (result.code_out !== want.code_out)
                        report_mismatch("code_out", result.code_out, want.code_out);
                    if (result.found !== want.found)
                        report_mismatch("found", result.found, want.found);
                    if (result.state_out !== want.state_out)
                        report_mismatch("state_out", result.state_out, want.state_out);
                    if (result.status !== want.status)
                        report_mismatch("status", result.status, want.status);
                end
            end
            if (cfg_we)
            begin
                case (cfg_idx)
                    sst_pkg::REG_CUR_LEVEL:  cur_level = cfg_wdata[3:0];
                    sst_pkg::REG_MAP_WIDTH:  map_w = cfg_wdata;
                    sst_pkg::REG_MAP_HEIGHT: map_h = cfg_wdata;
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                want = predict_switch(request);
                expected_results.push_back(want);
                status_count[want.status]++;
                reqs_taken++;
                req_taken <= 1'b1;
            end
            else
                req_taken <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done === 1'b1)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_MAX)
        begin
            $display("Timeout: no handshake for %0d cycles", STALL_MAX);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic wait_idle();
        do
            @(negedge clk);
        while (!(pending_reqs.size() == 0 && !start && expected_results.size() == 0 && !busy));
    endtask

    task automatic write_regs(bit [3:0] lvl, bit [8:0] w, bit [8:0] h, bit touch_spare);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= sst_pkg::REG_CUR_LEVEL;
        cfg_wdata <= {5'($urandom), lvl};
        @(negedge clk);
        cfg_idx <= sst_pkg::REG_MAP_WIDTH;
        cfg_wdata <= w;
        @(negedge clk);
        cfg_idx <= sst_pkg::REG_MAP_HEIGHT;
        cfg_wdata <= h;
        if (touch_spare)
        begin
            @(negedge clk);
            cfg_idx <= REG_SPARE;
            cfg_wdata <= 9'($urandom);
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Queue more finds on one level than it has slots, then random traffic
    task automatic queue_phase(int idle_pct, int n_random);
        bit [7:0] lvl;
        bit [7:0] y0;
        @(posedge clk);
        sender_idle_pct = idle_pct;
        lvl = 8'($urandom_range(0, LEVELS - 1));
        y0 = 8'($urandom_range(1, 6));
        for (int i = 0; i < 36; i++)
            pending_reqs.push_back(make_req(sst_pkg::MODE_FIND, lvl, 8'(1 + i % 9),
                                            8'(y0 + i / 9), 1'($urandom), 9'($urandom)));
        repeat (n_random)
            pending_reqs.push_back(random_request());
        wait_idle();
    endtask

    initial
    begin
        wipe_table();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part on the reset register values
        pending_reqs.push_back(make_req(sst_pkg::MODE_FIND, 8'd0, 8'd1, 8'd1, 1'b1, 9'h000));
        pending_reqs.push_back(make_req(sst_pkg::MODE_FIND, 8'd0, 8'd62, 8'd62, 1'b0, 9'h1FF));
        pending_reqs.push_back(make_req(sst_pkg::MODE_FIND, 8'd0, 8'd1, 8'd1, 1'b0, 9'h0AA));
        pending_reqs.push_back(make_req(sst_pkg::MODE_FIND, 8'hFF, 8'd5, 8'd5, 1'b1, 9'h155));
        pending_reqs.push_back(make_req(sst_pkg::MODE_FIND, 8'd15, 8'd62, 8'd1, 1'b1, 9'h000));
        pending_reqs.push_back(make_req(sst_pkg::MODE_FIND, 8'd16, 8'd2, 8'd2, 1'b0, 9'h000));
        pending_reqs.push_back(make_req(sst_pkg::MODE_FIND, 8'd254, 8'd2, 8'd2, 1'b0, 9'h000));
        pending_reqs.push_back(make_req(sst_pkg::MODE_FIND, 8'd1, 8'd0, 8'd2, 1'b0, 9'h000));
        pending_reqs.push_back(make_req(sst_pkg::MODE_FIND, 8'd1, 8'd63, 8'd2, 1'b0, 9'h000));
        pending_reqs.push_back(make_req(sst_pkg::MODE_FIND, 8'd1, 8'd2, 8'd63, 1'b0, 9'h000));
        pending_reqs.push_back(make_req(sst_pkg::MODE_FIND, 8'd1, 8'd2, 8'd0, 1'b0, 9'h000));
        pending_reqs.push_back(make_req(sst_pkg::MODE_FIND, 8'd1, 8'd255, 8'd255, 1'b1, 9'h000));
        pending_reqs.push_back(make_req(sst_pkg::MODE_SCAN, 8'd0, 8'd62, 8'd62, 1'b0, 9'h000));
        pending_reqs.push_back(make_req(sst_pkg::MODE_SCAN, 8'd0, 8'd9, 8'd9, 1'b0, 9'h000));
        pending_reqs.push_back(make_req(sst_pkg::MODE_SCAN, 8'd0, 8'd255, 8'd255, 1'b0, 9'h000));
        pending_reqs.push_back(make_req(sst_pkg::MODE_READ, 8'd0, 8'd0, 8'd0, 1'b0, 9'h000));
        pending_reqs.push_back(make_req(sst_pkg::MODE_READ, 8'd0, 8'd0, 8'd0, 1'b0, 9'h1FF));
        pending_reqs.push_back(make_req(sst_pkg::MODE_TOGGLE, 8'd0, 8'd0, 8'd0, 1'b0, 9'h001));
        pending_reqs.push_back(make_req(sst_pkg::MODE_TOGGLE, 8'd0, 8'd0, 8'd0, 1'b0, 9'h1FF));
        pending_reqs.push_back(make_req(sst_pkg::MODE_FIND, 8'd15, 8'd3, 8'd3, 1'b0, 9'h000));
        for (int m = MODE_NOP_FIRST; m <= MODE_NOP_LAST; m++)
            pending_reqs.push_back(make_req(3'(m), 8'hFF, 8'hFF, 8'hFF, 1'b1, 9'h1FF));
        pending_reqs.push_back(make_req(sst_pkg::MODE_CLEAR, 8'd0, 8'd0, 8'd0, 1'b0, 9'h000));
        pending_reqs.push_back(make_req(sst_pkg::MODE_READ, 8'd0, 8'd0, 8'd0, 1'b0, 9'h000));
        pending_reqs.push_back(make_req(sst_pkg::MODE_SCAN, 8'd0, 8'd1, 8'd1, 1'b0, 9'h000));
        wait_idle();

        queue_phase(0, 285);
        write_regs(4'd15, 9'd256, 9'd256, 1'b0);
        queue_phase(73, 285);
        write_regs(4'd5, 9'd3, 9'd3, 1'b0);
        queue_phase(0, 285);
        write_regs(4'd9, 9'd20, 9'd12, 1'b1);
        queue_phase(9, 285);
        write_regs(4'd2, 9'd511, 9'd130, 1'b0);
        queue_phase(73, 285);
        write_regs(4'd0, 9'd64, 9'd64, 1'b0);
        queue_phase(0, 285);

        // let any late strobe show up
        repeat (40) @(posedge clk);
        $display("Covered %0d requests and %0d checked results over six register settings,",
                 reqs_taken, results_checked);
        $display("  incl. %0d level errors, %0d coord errors, %0d full groups, %0d scan misses",
                 status_count[sst_pkg::ST_LEVEL], status_count[sst_pkg::ST_COORD],
                 status_count[sst_pkg::ST_FULL], status_count[sst_pkg::ST_NOT_FOUND]);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[segmented_switch_table.f]
src/sst_pkg.sv
src/sst_ctrl.sv
src/sst_dpath.sv
src/segmented_switch_table.sv
tb/sv/segmented_switch_table_tb.sv
